// File: hw/rtl/magma_pkg.sv
`timescale 1ns / 1ps
// Shared constants and functions for the masked-key Magma block cipher.
// Holds the GOST substitution tables, the round function and the key schedule.
// Depends on nothing.
package magma_pkg;

    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned KEY_WORDS = 8;
    localparam int unsigned ROT_AMT   = 11;

    // Register indexes on the configuration port (byte address / 8)
    localparam logic [2:0] REG_MASKED_KEY_01 = 3'd0;
    localparam logic [2:0] REG_MASKED_KEY_23 = 3'd1;
    localparam logic [2:0] REG_MASKED_KEY_45 = 3'd2;
    localparam logic [2:0] REG_MASKED_KEY_67 = 3'd3;
    localparam logic [2:0] REG_KEY_MASK_01   = 3'd4;
    localparam logic [2:0] REG_KEY_MASK_23   = 3'd5;
    localparam logic [2:0] REG_KEY_MASK_45   = 3'd6;
    localparam logic [2:0] REG_KEY_MASK_67   = 3'd7;

    localparam logic [0:0] MODE_DECRYPT = 1'b1;

    localparam logic [3:0] NIB_SUB [0:7][0:15] = '{
        '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
          4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
        '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
          4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
        '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
          4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
        '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
          4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
        '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
          4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
        '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
          4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
        '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
          4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
        '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
          4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
    };

    // Substitute each nibble, then rotate left
    function automatic logic [31:0] round_g(input logic [31:0] x);
        logic [31:0] y;
        y = '0;
        for (int b = 0; b < 4; b++)
        begin
            y[8*b +: 4]     = NIB_SUB[2*b][x[8*b +: 4]];
            y[8*b + 4 +: 4] = NIB_SUB[2*b + 1][x[8*b + 4 +: 4]];
        end
        return {y[31-ROT_AMT:0], y[31:32-ROT_AMT]};
    endfunction

    // Key word used by a round: descending order 7..0 or ascending 0..7
    function automatic logic [2:0] key_idx(input logic [4:0] rnd, input logic dec);
        logic desc;
        desc = dec ? (rnd[4:3] == 2'd0) : (rnd[4:3] != 2'd3);
        return desc ? ~rnd[2:0] : rnd[2:0];
    endfunction

endpackage

// File: hw/rtl/magma_block_cipher_masked_unit.sv
`timescale 1ns / 1ps
// Magma 64-bit block cipher with additively masked key words, fully unrolled.
// Throughput: one item per cycle; one register stage per Feistel round.
// busy never rises; the receiver cannot stall, so the pipeline always advances.
// Reset clears the key registers and the valid bits; payload stages are not reset.
module magma_block_cipher_masked_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [0:0]  mode,
    input  logic [63:0] block_in,
    output logic        done,
    output logic [63:0] block_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import magma_pkg::*;

    logic [63:0] masked_key_reg [0:3];
    logic [63:0] key_mask_reg [0:3];
    logic [31:0] rk_reg [0:KEY_WORDS-1];

    logic        valid_reg [0:ROUNDS];
    logic        dec_reg   [0:ROUNDS];
    logic [31:0] n1_reg    [0:ROUNDS];
    logic [31:0] n2_reg    [0:ROUNDS];

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                masked_key_reg[i] <= '0;
                key_mask_reg[i]   <= '0;
            end
        end
        else if (cfg_wr)
        begin
            if (cfg_idx[2])
                key_mask_reg[cfg_idx[1:0]] <= pwdata;
            else
                masked_key_reg[cfg_idx[1:0]] <= pwdata;
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MASKED_KEY_01: prdata = masked_key_reg[0];
            REG_MASKED_KEY_23: prdata = masked_key_reg[1];
            REG_MASKED_KEY_45: prdata = masked_key_reg[2];
            REG_MASKED_KEY_67: prdata = masked_key_reg[3];
            REG_KEY_MASK_01:   prdata = key_mask_reg[0];
            REG_KEY_MASK_23:   prdata = key_mask_reg[1];
            REG_KEY_MASK_45:   prdata = key_mask_reg[2];
            REG_KEY_MASK_67:   prdata = key_mask_reg[3];
            default:           prdata = '0;
        endcase
    end

    // Unmask the key words once, into registers that follow the key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
                rk_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < KEY_WORDS; i++)
                rk_reg[i] <= masked_key_reg[i/2][32*(i%2) +: 32]
                           - key_mask_reg[i/2][32*(i%2) +: 32];
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            dec_reg[0] <= (mode == MODE_DECRYPT);
            n1_reg[0]  <= block_in[31:0];
            n2_reg[0]  <= block_in[63:32];
        end
    end

    // One Feistel round per stage
    genvar r;
    generate
        for (r = 0; r < ROUNDS; r++)
        begin : g_round
            logic [31:0] half;
            logic [31:0] f;

            assign half = (r % 2 == 0) ? n1_reg[r] : n2_reg[r];
            assign f    = round_g(half + rk_reg[key_idx(5'(r), dec_reg[r])]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[r+1] <= 1'b0;
                else
                    valid_reg[r+1] <= valid_reg[r];
            end

            always_ff @(posedge clk)
            begin
                dec_reg[r+1] <= dec_reg[r];
                if (r % 2 == 0)
                begin
                    n1_reg[r+1] <= n1_reg[r];
                    n2_reg[r+1] <= n2_reg[r] ^ f;
                end
                else
                begin
                    n1_reg[r+1] <= n1_reg[r] ^ f;
                    n2_reg[r+1] <= n2_reg[r];
                end
            end
        end
    endgenerate

    assign done      = valid_reg[ROUNDS];
    assign block_out = {n1_reg[ROUNDS], n2_reg[ROUNDS]};

    // An item at the output entered the pipeline through the input stage and every round stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ROUNDS] |-> $past(valid_reg[0], ROUNDS))
        else $error("result without matching item");

    // Unmasked key word 0 is the registered difference of its key registers
    a_rk_track: assert property (@(posedge clk) disable iff (!rst_n)
        rk_reg[0] == $past(masked_key_reg[0][31:0] - key_mask_reg[0][31:0]))
        else $error("round key lost track of key registers");

    // A write to the first masked key register lands on the next edge
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && cfg_idx == REG_MASKED_KEY_01) |=> masked_key_reg[0] == $past(pwdata))
        else $error("configuration write dropped");

endmodule
